FILE: rtl/ipv4_route_lookup_decision_unit_macros.svh
// ----------------------------------------------------------------------------
// Route lookup decision unit: assertion macros
// Concurrent check macros used by the top-level RTL file; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef IPV4_ROUTE_LOOKUP_DECISION_UNIT_MACROS_SVH
`define IPV4_ROUTE_LOOKUP_DECISION_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RLU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("route lookup assertion failed");
// next-cycle implication
`define RLU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("route lookup assertion failed");
`else
`define RLU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RLU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/rlu_pkg.sv
// ----------------------------------------------------------------------------
// Route lookup decision unit: package
// Command and action codes, and the lookup item and write structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rlu_pkg;

    typedef enum logic [1:0] {
        CMD_LOOKUP    = 2'd0,
        CMD_WR_ROUTE  = 2'd1,
        CMD_WR_OWN    = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_FORWARD       = 2'd0,
        ACT_ECHO_REPLY    = 2'd1,
        ACT_TIME_EXCEEDED = 2'd2,
        ACT_NET_UNREACH   = 2'd3
    } t_act;

    // lookup item as it travels down the route chain
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [7:0]  ttl;
        logic        fixed;      // action decided before the route search
        t_act        fixed_act;
        logic        found;
        logic [31:0] best;       // mask of the best match so far
        logic [1:0]  port;
    } t_tok;

    // route write toward one cell
    typedef struct packed {
        logic        en;
        logic        clr;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [1:0]  port;
    } t_wr;

endpackage

`default_nettype wire

FILE: rtl/rlu_route_cell.sv
// ----------------------------------------------------------------------------
// Route lookup: route cell
// Holds one route entry and updates the best match of a passing lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_route_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_adv,
    input  wire rlu_pkg::t_wr  i_wr,
    input  wire rlu_pkg::t_tok i_tok,
    output rlu_pkg::t_tok      o_tok
);

    logic          r_valid;
    logic [31:0]   r_dest;
    logic [31:0]   r_mask;
    logic [1:0]    r_port;
    rlu_pkg::t_tok r_tok;
    rlu_pkg::t_tok n_tok;
    logic          w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr.clr) begin
            r_valid <= 1'b0;
        end else if (i_wr.en) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_dest <= i_wr.dest;
            r_mask <= i_wr.mask;
            r_port <= i_wr.port;
        end
    end

    assign w_match = r_valid && (((r_dest ^ i_tok.addr) & r_mask) == 32'd0);

    // later entries win ties
    always_comb begin
        n_tok = i_tok;
        if (w_match && (!i_tok.found || (r_mask >= i_tok.best))) begin
            n_tok.found = 1'b1;
            n_tok.best  = r_mask;
            n_tok.port  = r_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: rtl/rlu_own_tbl.sv
// ----------------------------------------------------------------------------
// Route lookup: own address table
// Holds the router's own addresses and flags a destination that hits one.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_own_tbl #(
    parameter int LOCALS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire logic        i_clr,
    input  wire logic [3:0]  i_slot,
    input  wire logic [31:0] i_addr,
    output logic             o_hit
);

    logic [LOCALS-1:0] r_valid;
    logic [31:0]       r_addr [LOCALS];
    logic [LOCALS-1:0] w_hit;

    for (genvar k = 0; k < LOCALS; k++) begin : g_ent
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_clr) begin
                r_valid[k] <= 1'b0;
            end else if (i_wr_en && (32'(i_slot) == k)) begin
                r_valid[k] <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (32'(i_slot) == k)) begin
                r_addr[k] <= i_addr;
            end
        end

        assign w_hit[k] = r_valid[k] && (r_addr[k] == i_addr);
    end

    assign o_hit = |w_hit;

endmodule

`default_nettype wire

FILE: rtl/ipv4_route_lookup_decision_unit.sv
// ----------------------------------------------------------------------------
// IPv4 route lookup decision unit
// Route table in a chain of cells plus an own-address table; one action
// per lookup item.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis_*; tuser carries the command (lookup,
//   route write, own-address write, clear tables). Only a lookup gives a
//   result item on m_axis_*, with the action in tuser and the egress
//   interface and new TTL in tdata.
//   A lookup enters the first route cell at acceptance and moves one cell
//   per cycle while the output can advance; from the last cell the result
//   item goes into the output register. While a lookup is in the chain no
//   input item is taken; write and clear items give no result and do not
//   hold off the next item.
//   The own-address check and the TTL check are done at acceptance.
//   Reset clears both tables and drops any lookup in flight; no item is
//   taken while reset is held.
//   When the receiver stalls, the result waits in the output register and
//   the chain holds; a new item is taken only when the output can advance.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_route_lookup_decision_unit_macros.svh"

module ipv4_route_lookup_decision_unit #(
    parameter int ROUTES = 16,
    parameter int LOCALS = 4,
    parameter int IFACES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // slot[3:0], addr[35:4], net_mask[67:36], egress[69:68], ttl[77:70],
    // is_echo[78], zero[79]
    input  wire logic [79:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_iface[1:0], new_ttl[9:2], zero[15:10]
    output logic [15:0]      m_axis_tdata,
    // action[1:0]
    output logic [1:0]       m_axis_tuser
);

    rlu_pkg::t_cmd  w_cmd;
    logic           w_accept;
    logic           w_adv;
    logic           w_own_hit;
    logic [3:0]     w_slot;
    logic [31:0]    w_addr;
    logic [31:0]    w_mask;
    logic [1:0]     w_egress;
    logic [7:0]     w_ttl;
    logic           w_echo;
    logic           w_route_ok;
    rlu_pkg::t_tok  w_tok [ROUTES+1];
    logic [ROUTES-1:0] w_vld;
    rlu_pkg::t_tok  w_last;

    logic           r_busy;
    logic           r_out_valid;
    rlu_pkg::t_act  r_out_act;
    logic [1:0]     r_out_iface;
    logic [7:0]     r_out_ttl;
    rlu_pkg::t_act  n_out_act;
    logic [1:0]     n_out_iface;
    logic [7:0]     n_out_ttl;

    assign w_cmd    = rlu_pkg::t_cmd'(s_axis_tuser);
    assign w_slot   = s_axis_tdata[3:0];
    assign w_addr   = s_axis_tdata[35:4];
    assign w_mask   = s_axis_tdata[67:36];
    assign w_egress = s_axis_tdata[69:68];
    assign w_ttl    = s_axis_tdata[77:70];
    assign w_echo   = s_axis_tdata[78];

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = i_rst_n && !r_busy && w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    rlu_own_tbl #(
        .LOCALS (LOCALS)
    ) u_own (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (w_accept && (w_cmd == rlu_pkg::CMD_WR_OWN)),
        .i_clr   (w_accept && (w_cmd == rlu_pkg::CMD_CLEAR)),
        .i_slot  (w_slot),
        .i_addr  (w_addr),
        .o_hit   (w_own_hit)
    );

    // expired TTL wins over echo reply
    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].valid     = w_accept && (w_cmd == rlu_pkg::CMD_LOOKUP);
        w_tok[0].addr      = w_addr;
        w_tok[0].ttl       = w_ttl;
        w_tok[0].fixed_act = rlu_pkg::ACT_TIME_EXCEEDED;
        if (w_ttl <= 8'd1) begin
            w_tok[0].fixed = 1'b1;
        end else if (w_echo && w_own_hit) begin
            w_tok[0].fixed     = 1'b1;
            w_tok[0].fixed_act = rlu_pkg::ACT_ECHO_REPLY;
        end
    end

    assign w_route_ok = w_accept && (w_cmd == rlu_pkg::CMD_WR_ROUTE)
                        && (32'(w_egress) < IFACES);

    for (genvar k = 0; k < ROUTES; k++) begin : g_cell
        rlu_pkg::t_wr w_wr;

        always_comb begin
            w_wr.en   = w_route_ok && (32'(w_slot) == k);
            w_wr.clr  = w_accept && (w_cmd == rlu_pkg::CMD_CLEAR);
            w_wr.dest = w_addr;
            w_wr.mask = w_mask;
            w_wr.port = w_egress;
        end

        rlu_route_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_wr    (w_wr),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );

        assign w_vld[k] = w_tok[k+1].valid;
    end

    assign w_last = w_tok[ROUTES];

    always_comb begin
        n_out_iface = 2'd0;
        n_out_ttl   = w_last.ttl;
        if (w_last.fixed) begin
            n_out_act = w_last.fixed_act;
        end else if (w_last.found) begin
            n_out_act   = rlu_pkg::ACT_FORWARD;
            n_out_iface = w_last.port;
            n_out_ttl   = w_last.ttl - 8'd1;
        end else begin
            n_out_act = rlu_pkg::ACT_NET_UNREACH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && (w_cmd == rlu_pkg::CMD_LOOKUP)) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_last.valid) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= w_last.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_last.valid) begin
            r_out_act   <= n_out_act;
            r_out_iface <= n_out_iface;
            r_out_ttl   <= n_out_ttl;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_act;
    assign m_axis_tdata  = {6'd0, r_out_ttl, r_out_iface};

    `RLU_ASSERT_IMP(a_one_lookup, i_clk, i_rst_n, 1'b1, $onehot0(w_vld))
    `RLU_ASSERT_IMP(a_busy_tracks_chain, i_clk, i_rst_n, 1'b1, r_busy == (|w_vld))
    `RLU_ASSERT_NXT(a_lookup_sets_busy, i_clk, i_rst_n,
        w_accept && (w_cmd == rlu_pkg::CMD_LOOKUP), r_busy)
    `RLU_ASSERT_IMP(a_iface_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_act != rlu_pkg::ACT_FORWARD), r_out_iface == 2'd0)

endmodule

`default_nettype wire

FILE: tb/sv/ipv4_route_lookup_decision_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 route lookup decision unit testbench
// Drives route writes, own-address writes, table clears and lookups on the
// input stream with random gaps and a long output stall. It keeps its own
// copy of both tables, predicts each lookup's action, interface and TTL,
// and checks every result item in order against that prediction.
// ----------------------------------------------------------------------------

module ipv4_route_lookup_decision_unit_tb;

    localparam int N_ROUTES    = 16;
    localparam int N_LOCALS    = 4;
    localparam int N_IFACES    = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 950;

    typedef struct packed {
        rlu_pkg::t_act action;
        logic [1:0]    iface;
        logic [7:0]    ttl;
    } t_decision;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // slot[3:0], addr[35:4], net_mask[67:36], egress[69:68], ttl[77:70],
    // is_echo[78], zero[79]
    logic [79:0] s_axis_tdata;
    // cmd[1:0]
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // out_iface[1:0], new_ttl[9:2], zero[15:10]
    logic [15:0] m_axis_tdata;
    // action[1:0]
    logic [1:0]  m_axis_tuser;

    // predicted state of the block
    logic [31:0] route_dest  [N_ROUTES];
    logic [31:0] route_mask  [N_ROUTES];
    logic [1:0]  route_port  [N_ROUTES];
    logic        route_valid [N_ROUTES];
    logic [31:0] own_addr    [N_LOCALS];
    logic        own_valid   [N_LOCALS];
    t_decision   pending_decisions[$];

    // what the stimulus has written so far, used to aim lookups
    logic [31:0] sent_dest [N_ROUTES];
    logic [31:0] sent_own  [N_LOCALS];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int sink_hold    = 0;
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;

    always #5 i_clk = ~i_clk;

    ipv4_route_lookup_decision_unit #(
        .ROUTES(N_ROUTES),
        .LOCALS(N_LOCALS),
        .IFACES(N_IFACES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function automatic void clear_route_state();
        for (int k = 0; k < N_ROUTES; k++) begin
            route_dest[k]  = '0;
            route_mask[k]  = '0;
            route_port[k]  = '0;
            route_valid[k] = 1'b0;
        end
        for (int k = 0; k < N_LOCALS; k++) begin
            own_addr[k]  = '0;
            own_valid[k] = 1'b0;
        end
    endfunction

    function automatic t_decision predict_decision(input logic [31:0] dst,
                                                   input logic [7:0] ttl,
                                                   input logic echo);
        t_decision   d;
        logic        own;
        logic        hit;
        logic [31:0] best;
        logic [1:0]  port;
        d.action = rlu_pkg::ACT_NET_UNREACH;
        d.iface  = 2'd0;
        d.ttl    = ttl;
        own  = 1'b0;
        hit  = 1'b0;
        best = '0;
        port = '0;
        for (int k = 0; k < N_LOCALS; k++)
            if (own_valid[k] && own_addr[k] == dst)
                own = 1'b1;
        if (ttl <= 8'd1) begin
            d.action = rlu_pkg::ACT_TIME_EXCEEDED;
        end else if (echo && own) begin
            d.action = rlu_pkg::ACT_ECHO_REPLY;
        end else begin
            // largest mask wins, later slot on a tie
            for (int k = 0; k < N_ROUTES; k++) begin
                if (route_valid[k] && ((route_dest[k] ^ dst) & route_mask[k]) == 32'h0
                        && (!hit || route_mask[k] >= best)) begin
                    hit  = 1'b1;
                    best = route_mask[k];
                    port = route_port[k];
                end
            end
            if (hit) begin
                d.action = rlu_pkg::ACT_FORWARD;
                d.iface  = port;
                d.ttl    = ttl - 8'd1;
            end
        end
        return d;
    endfunction

    // update tables and queue predictions in acceptance order
    always @(posedge i_clk) begin : accept_monitor
        rlu_pkg::t_cmd cmd;
        logic [3:0]    slot;
        logic [31:0]   addr;
        logic [31:0]   mask;
        logic [1:0]    egress;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            cmd    = rlu_pkg::t_cmd'(s_axis_tuser);
            slot   = s_axis_tdata[3:0];
            addr   = s_axis_tdata[35:4];
            mask   = s_axis_tdata[67:36];
            egress = s_axis_tdata[69:68];
            case (cmd)
                rlu_pkg::CMD_WR_ROUTE: begin
                    if (slot < N_ROUTES && egress < N_IFACES) begin
                        route_dest[slot]  = addr;
                        route_mask[slot]  = mask;
                        route_port[slot]  = egress;
                        route_valid[slot] = 1'b1;
                    end
                end
                rlu_pkg::CMD_WR_OWN: begin
                    if (slot < N_LOCALS) begin
                        own_addr[slot]  = addr;
                        own_valid[slot] = 1'b1;
                    end
                end
                rlu_pkg::CMD_CLEAR: begin
                    clear_route_state();
                end
                default: begin
                    pending_decisions.push_back(
                        predict_decision(addr, s_axis_tdata[77:70], s_axis_tdata[78]));
                end
            endcase
        end
    end

    task automatic note_mismatch(input string what, input t_decision want,
                                 input t_decision got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected action %s iface %0d ttl %0d, %s %s %s %0d %s %0d",
                     $realtime, what, want.action.name(), want.iface, want.ttl,
                     "got action", got.action.name(), "iface", got.iface,
                     "ttl", got.ttl);
    endtask

    always @(posedge i_clk) begin : result_check
        t_decision got;
        t_decision want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action = rlu_pkg::t_act'(m_axis_tuser);
            got.iface  = m_axis_tdata[1:0];
            got.ttl    = m_axis_tdata[9:2];
            if (pending_decisions.size() == 0) begin
                want = '0;
                note_mismatch("unexpected result", want, got);
            end else begin
                want = pending_decisions.pop_front();
                if (got.action !== want.action || got.iface !== want.iface
                        || got.ttl !== want.ttl)
                    note_mismatch("wrong result", want, got);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side: random stall before each item when rx_idle is set, long hold on request
    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold != 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready) && sink_hold == 0);
        end
    end

    task automatic send_item(input rlu_pkg::t_cmd cmd, input logic [3:0] slot,
                             input logic [31:0] addr, input logic [31:0] mask,
                             input logic [1:0] egress, input logic [7:0] ttl,
                             input logic echo);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, echo, ttl, egress, mask, addr, slot};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_lookup(input logic [31:0] addr, input logic [7:0] ttl,
                               input logic echo);
        send_item(rlu_pkg::CMD_LOOKUP, 4'($urandom), addr, 32'($urandom), 2'($urandom),
                  ttl, echo);
    endtask

    task automatic send_route(input logic [3:0] slot, input logic [31:0] dest,
                              input logic [31:0] mask, input logic [1:0] egress);
        send_item(rlu_pkg::CMD_WR_ROUTE, slot, dest, mask, egress, 8'($urandom),
                  1'($urandom));
        sent_dest[slot] = dest;
    endtask

    task automatic send_own(input logic [3:0] slot, input logic [31:0] addr);
        send_item(rlu_pkg::CMD_WR_OWN, slot, addr, 32'($urandom), 2'($urandom),
                  8'($urandom), 1'($urandom));
        if (slot < N_LOCALS)
            sent_own[slot] = addr;
    endtask

    task automatic test_empty_tables();
        send_lookup(32'h0000_0000, 8'd64, 1'b0);
        // expired packets, TTL zero included
        send_lookup(32'hFFFF_FFFF, 8'd0, 1'b1);
        send_lookup(32'h0A01_0203, 8'd1, 1'b0);
    endtask

    task automatic test_route_match();
        send_route(4'd0, 32'h0000_0000, 32'h0000_0000, 2'd1);
        send_route(4'd5, 32'h0A00_0000, prefix_mask(8), 2'd2);
        send_route(4'd3, 32'h0A01_0000, prefix_mask(16), 2'd3);
        // same prefix in a later slot takes the tie; host bits do not matter
        send_route(4'd9, 32'h0A01_FFFF, prefix_mask(16), 2'd0);
        send_lookup(32'h0A01_0203, 8'd255, 1'b0);
        send_lookup(32'h0A02_0000, 8'd2, 1'b0);
        send_lookup(32'hC0A8_0101, 8'd64, 1'b1);
        send_route(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
        send_lookup(32'hFFFF_FFFF, 8'd2, 1'b0);
    endtask

    task automatic test_own_address();
        send_own(4'd0, 32'hC0A8_0001);
        send_own(4'd3, 32'h0A01_0203);
        send_own(4'd15, 32'h0A02_0304);
        send_lookup(32'hC0A8_0001, 8'd64, 1'b1);
        send_lookup(32'h0A02_0304, 8'd64, 1'b1);
        send_lookup(32'h0A01_0203, 8'd9, 1'b0);
        // expiry beats echo reply
        send_lookup(32'h0A01_0203, 8'd1, 1'b1);
    endtask

    task automatic test_clear_tables();
        send_item(rlu_pkg::CMD_CLEAR, 4'd0, 32'h0, 32'h0, 2'd0, 8'd0, 1'b0);
        send_lookup(32'hC0A8_0001, 8'd64, 1'b1);
    endtask

    task automatic test_backpressure();
        bit saved;
        saved   = tx_idle;
        tx_idle = 1'b0;
        send_route(4'd7, 32'h0000_0000, 32'h0000_0000, 2'd2);
        sink_hold = 300;
        for (int n = 0; n < 24; n++)
            send_lookup(32'($urandom), 8'($urandom_range(0, 255)), 1'($urandom));
        tx_idle = saved;
    endtask

    task automatic test_random_traffic();
        int          pick;
        int          len;
        logic [3:0]  slot;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [7:0]  ttl;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 17) begin
                slot = 4'($urandom);
                len  = $urandom_range(0, 32);
                mask = ($urandom_range(0, 9) == 0) ? 32'($urandom) : prefix_mask(len);
                addr = 32'($urandom);
                // nest under an existing route half the time
                if ($urandom_range(0, 1) != 0) begin
                    mask = prefix_mask(len);
                    addr = (sent_dest[$urandom_range(0, N_ROUTES - 1)]
                            & prefix_mask($urandom_range(0, len))) | (addr & ~mask)
                           | (addr & mask & ~prefix_mask(len));
                end
                send_route(slot, addr, mask, 2'($urandom));
            end else if (pick < 27) begin
                addr = ($urandom_range(0, 1) != 0)
                       ? sent_dest[$urandom_range(0, N_ROUTES - 1)] : 32'($urandom);
                send_own(4'($urandom), addr);
            end else if (pick < 29) begin
                send_item(rlu_pkg::CMD_CLEAR, 4'($urandom), 32'($urandom), 32'($urandom),
                          2'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                case ($urandom_range(0, 5))
                    0, 1, 2: begin
                        mask = prefix_mask($urandom_range(0, 32));
                        addr = (sent_dest[$urandom_range(0, N_ROUTES - 1)] & mask)
                               | (32'($urandom) & ~mask);
                    end
                    3: addr = sent_own[$urandom_range(0, N_LOCALS - 1)];
                    default: addr = 32'($urandom);
                endcase
                case ($urandom_range(0, 11))
                    0: ttl = 8'd0;
                    1: ttl = 8'd1;
                    2: ttl = 8'd2;
                    3: ttl = 8'd255;
                    default: ttl = 8'($urandom_range(0, 255));
                endcase
                send_lookup(addr, ttl, ($urandom_range(0, 2) != 0));
            end
        end
    endtask

    initial begin : run
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rlu_pkg::CMD_LOOKUP;
        i_rst_n       <= 1'b0;
        clear_route_state();
        for (int k = 0; k < N_ROUTES; k++) sent_dest[k] = '0;
        for (int k = 0; k < N_LOCALS; k++) sent_own[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tables();
        test_route_match();
        test_own_address();
        test_clear_tables();
        test_backpressure();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge i_clk);
        // drain: catch any stray result from the chain
        repeat (N_ROUTES + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
